// ===== hw/rtl/wpcm_pkg.sv =====
// Shared constants and types for the sliding-window peak counter.
// No dependencies; imported by every module of the block.
package wpcm_pkg;

    localparam int MAX_WINDOW = 1024;
    localparam int MAX_LENGTH = 65536;

    localparam int SAMPLE_W   = 32;
    localparam int CNT_W      = $clog2(MAX_WINDOW);      // peak count, 0..MAX_WINDOW-1
    localparam int LEN_W      = CNT_W + 1;               // window length register
    localparam int IDX_W      = $clog2(MAX_LENGTH) + 1;  // samples taken, 0..MAX_LENGTH
    localparam int START_W    = $clog2(MAX_LENGTH);     // 0-based window start

    // Programmable delay line: a flag enters at cell MAX_WINDOW-k and leaves
    // at the last cell k-2 shifts later.
    localparam int CHAIN_LEN  = MAX_WINDOW - 2;
    localparam int CELL_IDX_W = $clog2(CHAIN_LEN);

    typedef logic [SAMPLE_W-1:0]   t_sample;
    typedef logic [CNT_W-1:0]      t_count;
    typedef logic [LEN_W-1:0]      t_len;
    typedef logic [IDX_W-1:0]      t_index;
    typedef logic [START_W-1:0]    t_start;
    typedef logic [CELL_IDX_W-1:0] t_cell_idx;

    // Per-cell control
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

    // Control from the top level to the delay chain
    typedef struct packed {
        logic      shift;
        t_cell_idx ins_idx;
    } t_chain_ctl;

endpackage

// ===== hw/rtl/wpcm_cell.sv =====
// One stage of the peak-flag delay chain.
// Depends on wpcm_pkg.
module wpcm_cell (
    input  logic                i_clk,
    input  wpcm_pkg::t_cell_ctl i_ctl,
    input  logic                i_new_flag,
    input  logic                i_prev_flag,
    output logic                o_flag
);
    import wpcm_pkg::*;

    logic r_flag;
    logic n_flag;

    // Load point takes the fresh flag, every other cell takes its neighbor's.
    always_comb begin
        n_flag = r_flag;
        if (i_ctl.shift) begin
            n_flag = i_ctl.load ? i_new_flag : i_prev_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_flag <= n_flag;
    end

    assign o_flag = r_flag;

endmodule

// ===== hw/rtl/wpcm_chain.sv =====
// Row of wpcm_cell stages forming a delay line with a movable entry point.
// Depends on wpcm_pkg and wpcm_cell.
module wpcm_chain (
    input  logic                 i_clk,
    input  wpcm_pkg::t_chain_ctl i_ctl,
    input  logic                 i_new_flag,
    output logic                 o_tap
);
    import wpcm_pkg::*;

    logic [CHAIN_LEN-1:0] flags;

    for (genvar g = 0; g < CHAIN_LEN; g++) begin : g_cell
        t_cell_ctl cell_ctl;
        logic      prev_flag;

        assign cell_ctl.shift = i_ctl.shift;
        assign cell_ctl.load  = (i_ctl.ins_idx == CELL_IDX_W'(g));

        if (g == 0) begin : g_head
            assign prev_flag = 1'b0;
        end else begin : g_body
            assign prev_flag = flags[g-1];
        end

        wpcm_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (cell_ctl),
            .i_new_flag  (i_new_flag),
            .i_prev_flag (prev_flag),
            .o_flag      (flags[g])
        );
    end

    assign o_tap = flags[CHAIN_LEN-1];

endmodule

// ===== hw/rtl/window_peak_count_max_core.sv =====
// Top level of the sliding-window peak counter.
// Depends on wpcm_pkg and wpcm_chain.
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one sample per request,
//   with i_last marking the final sample of a sequence. A sample is a peak
//   when strictly greater than both neighbors. For every window of
//   window_len samples inside the sequence the peaks strictly inside it are
//   counted; the largest count and the leftmost window reaching it are kept.
//   Output channel (o_out_valid / i_out_ready) carries one result request per
//   sequence: o_peak_total = best count + 1, o_left_edge = 1-based start.
//   Throughput: one sample per cycle while o_in_ready is high; each step is
//   compare and add; the flag delay chain shifts once per accepted sample
//   below MAX_LENGTH. Result: registered, it shows in the cycle after the
//   last sample is accepted.
//   Stall: the output register holds the result; input is still accepted
//   while the output slot is empty or being drained in the same cycle.
//   Reset: window_len = 3, sequence state cleared, output slot empty. The
//   delay chain needs no clearing, every flag is rewritten before it is read.
//   Config: i_cfg_wr_en writes window_len (saturated to 3..1024) and starts
//   a new sequence; write it only while the block is idle.
module window_peak_count_max_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  wpcm_pkg::t_sample      i_sample,
    input  logic                   i_last,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output wpcm_pkg::t_count       o_peak_total,
    output wpcm_pkg::t_index       o_left_edge,
    input  logic                   i_cfg_wr_en,
    input  wpcm_pkg::t_len         i_cfg_wr_data
);
    import wpcm_pkg::*;

    // Window length saturated into 3..MAX_WINDOW
    function automatic t_len sat_len(input t_len v);
        t_len k;
        k = v;
        if (v < LEN_W'(3)) begin
            k = LEN_W'(3);
        end else if (v > LEN_W'(MAX_WINDOW)) begin
            k = LEN_W'(MAX_WINDOW);
        end
        return k;
    endfunction

    // Config-derived: k-1 and the chain entry cell MAX_WINDOW-k
    t_count    r_k_m1,    n_k_m1;
    t_cell_idx r_ins_idx, n_ins_idx;

    // Sequence state
    t_sample   r_older,      n_older;
    t_sample   r_newer,      n_newer;
    t_count    r_count,      n_count;
    t_count    r_best_count, n_best_count;
    t_start    r_best_start, n_best_start;
    t_index    r_idx,        n_idx;

    // Output slot
    logic      r_out_valid,  n_out_valid;
    t_count    r_peak_total, n_peak_total;
    t_index    r_left_edge,  n_left_edge;

    logic       accept;
    logic       active;
    logic       flag;
    logic       win;
    logic       old_flag;
    t_count     cnt_add;
    t_count     cnt_sub;
    t_index     start_full;
    t_start     start;
    t_len       k_new;
    t_chain_ctl chain_ctl;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    // Samples past MAX_LENGTH are dropped, only their last flag counts
    assign active     = (r_idx < IDX_W'(MAX_LENGTH));

    // Flag for the previous sample, decided now that its right neighbor is here
    assign flag = (r_idx >= IDX_W'(2)) && (r_newer > r_older) && (r_newer > i_sample);

    assign cnt_add    = r_count + CNT_W'(flag);
    assign win        = (r_idx >= IDX_W'(r_k_m1));
    assign start_full = r_idx - IDX_W'(r_k_m1);
    assign start      = start_full[START_W-1:0];
    // Window start leaves the interior; its flag exits the chain now
    assign cnt_sub    = (cnt_add >= CNT_W'(old_flag)) ? cnt_add - CNT_W'(old_flag) : '0;

    assign chain_ctl.shift   = accept && active;
    assign chain_ctl.ins_idx = r_ins_idx;

    wpcm_chain u_chain (
        .i_clk      (i_clk),
        .i_ctl      (chain_ctl),
        .i_new_flag (flag),
        .o_tap      (old_flag)
    );

    always_comb begin
        k_new        = sat_len(i_cfg_wr_data);
        n_k_m1       = r_k_m1;
        n_ins_idx    = r_ins_idx;
        n_older      = r_older;
        n_newer      = r_newer;
        n_count      = r_count;
        n_best_count = r_best_count;
        n_best_start = r_best_start;
        n_idx        = r_idx;
        n_out_valid  = r_out_valid;
        n_peak_total = r_peak_total;
        n_left_edge  = r_left_edge;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (accept) begin
            if (active) begin
                n_count = win ? cnt_sub : cnt_add;
                if (win && (start == '0 || cnt_sub > r_best_count)) begin
                    n_best_count = cnt_sub;
                    n_best_start = start;
                end
                n_older = r_newer;
                n_newer = i_sample;
                n_idx   = r_idx + IDX_W'(1);
            end
            if (i_last) begin
                n_out_valid  = 1'b1;
                n_peak_total = n_best_count + CNT_W'(1);
                n_left_edge  = IDX_W'(n_best_start) + IDX_W'(1);
                n_older      = '0;
                n_newer      = '0;
                n_count      = '0;
                n_best_count = '0;
                n_best_start = '0;
                n_idx        = '0;
            end
        end

        if (i_cfg_wr_en) begin
            n_k_m1       = CNT_W'(k_new - LEN_W'(1));
            n_ins_idx    = CELL_IDX_W'(LEN_W'(MAX_WINDOW) - k_new);
            n_older      = '0;
            n_newer      = '0;
            n_count      = '0;
            n_best_count = '0;
            n_best_start = '0;
            n_idx        = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_m1       <= CNT_W'(2);
            r_ins_idx    <= CELL_IDX_W'(MAX_WINDOW - 3);
            r_older      <= '0;
            r_newer      <= '0;
            r_count      <= '0;
            r_best_count <= '0;
            r_best_start <= '0;
            r_idx        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_k_m1       <= n_k_m1;
            r_ins_idx    <= n_ins_idx;
            r_older      <= n_older;
            r_newer      <= n_newer;
            r_count      <= n_count;
            r_best_count <= n_best_count;
            r_best_start <= n_best_start;
            r_idx        <= n_idx;
            r_out_valid  <= n_out_valid;
        end
        r_peak_total <= n_peak_total;
        r_left_edge  <= n_left_edge;
    end

    assign o_out_valid  = r_out_valid;
    assign o_peak_total = r_peak_total;
    assign o_left_edge  = r_left_edge;

    // Entry cell and window length stay consistent
    a_ins_matches_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (LEN_W'(r_ins_idx) + LEN_W'(r_k_m1)) == LEN_W'(MAX_WINDOW - 1))
        else $error("chain entry point out of step with window length");

    // Running count never exceeds k-1 (r_k_m1)
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_k_m1)
        else $error("running peak count exceeds window");

    // A last sample always restarts the sequence
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_last |=> r_idx == '0 && r_count == '0)
        else $error("sequence state not cleared after last sample");

    // Emitted result fields are never zero
    a_result_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_peak_total != '0) && (r_left_edge != '0))
        else $error("zero field in result");

endmodule

// ===== bench/peak_window_checker.sv =====
`timescale 1ns / 100ps
// Checker for window_peak_count_max_core: follows window_len writes and accepted
// samples, predicts the best peak window per sequence and compares each result.
// Depends on wpcm_pkg.
module peak_window_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  wpcm_pkg::t_sample i_sample,
    input  logic              i_last,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  wpcm_pkg::t_count  i_peak_total,
    input  wpcm_pkg::t_index  i_left_edge,
    input  logic              i_cfg_wr_en,
    input  wpcm_pkg::t_len    i_cfg_wr_data,
    output int                o_fail_count,
    output int                o_pending
);
    import wpcm_pkg::*;

    typedef struct {
        t_count peak_total;
        t_index left_edge;
    } t_best_window;

    t_best_window best_window_q[$];

    t_len        span_reg;
    t_sample     prev_far;
    t_sample     prev_near;
    bit          peak_flag [MAX_WINDOW];
    int unsigned run_peaks;
    int unsigned best_peaks;
    int unsigned best_left;
    int unsigned seq_pos;
    int          mismatches = 0;

    task automatic restart_sequence();
        prev_far   = '0;
        prev_near  = '0;
        run_peaks  = 0;
        best_peaks = 0;
        best_left  = 0;
        seq_pos    = 0;
    endtask

    // One accepted sample: settle the flag of the previous position, slide the
    // window, and queue the result when the sequence ends.
    task automatic advance_peak_window(input t_sample s, input logic l);
        int unsigned  width;
        int unsigned  start_pos;
        int unsigned  leaving;
        bit           is_peak;
        t_best_window res;
        width = (span_reg < 3) ? 3 : ((span_reg > MAX_WINDOW) ? MAX_WINDOW : span_reg);
        if (seq_pos < MAX_LENGTH) begin
            if (seq_pos >= 1) begin
                is_peak = (seq_pos >= 2) && (prev_near > prev_far) && (prev_near > s);
                peak_flag[(seq_pos - 1) % MAX_WINDOW] = is_peak;
                run_peaks += is_peak;
            end
            if (seq_pos >= width - 1) begin
                start_pos = seq_pos - (width - 1);
                leaving   = peak_flag[start_pos % MAX_WINDOW];
                run_peaks = (run_peaks >= leaving) ? run_peaks - leaving : 0;
                if (start_pos == 0 || run_peaks > best_peaks) begin
                    best_peaks = run_peaks;
                    best_left  = start_pos;
                end
            end
            prev_far  = prev_near;
            prev_near = s;
            seq_pos++;
        end
        if (l) begin
            res.peak_total = t_count'(best_peaks + 1);
            res.left_edge  = t_index'(best_left + 1);
            best_window_q  = {best_window_q, res};
            restart_sequence();
        end
    endtask

    task automatic compare_result();
        t_best_window want;
        if (best_window_q.size() == 0) begin
            if (mismatches < 10)
                $display("%0t: result with none pending: peak_total=%0d left_edge=%0d",
                         $realtime, i_peak_total, i_left_edge);
            mismatches++;
        end else begin
            want = best_window_q.pop_front();
            if (want.peak_total !== i_peak_total || want.left_edge !== i_left_edge) begin
                if (mismatches < 10)
                    $display("%0t: mismatch: expected peak_total=%0d left_edge=%0d, got %0d %0d",
                             $realtime, want.peak_total, want.left_edge,
                             i_peak_total, i_left_edge);
                mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            span_reg = LEN_W'(3);
            foreach (peak_flag[n]) peak_flag[n] = 1'b0;
            restart_sequence();
            best_window_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                span_reg = i_cfg_wr_data;
                restart_sequence();
            end
            if (i_in_valid && i_in_ready)
                advance_peak_window(i_sample, i_last);
            if (i_out_valid && i_out_ready)
                compare_result();
        end
        o_pending    <= best_window_q.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Top of the window_peak_count_max_core bench: clock, reset, sample stimulus,
// window_len writes and the verdict. Depends on wpcm_pkg and peak_window_checker.
module testbench;
    import wpcm_pkg::*;

    localparam int IDLE_PCT     = 36;    // percent of cycles each side idles
    localparam int RESET_CYCLES = 6;
    localparam int STALL_LIMIT  = 2000;  // cycles with no request moving
    localparam int SETTLE       = 3;     // result shows in the cycle after last

    typedef enum int {
        FILL_SMALL,    // tiny values: many peaks and ties
        FILL_FULL,     // full 32-bit random
        FILL_EXTREME,  // only all-zero or all-one
        FILL_FLAT,     // one value for the whole sequence
        FILL_ZIGZAG    // low/high alternation, densest peaks
    } t_fill;

    logic    clk         = 1'b0;
    logic    rst_n       = 1'b0;
    logic    in_valid    = 1'b0;
    t_sample in_sample   = '0;
    logic    in_last     = 1'b0;
    logic    out_ready   = 1'b0;
    logic    cfg_wr_en   = 1'b0;
    t_len    cfg_wr_data = '0;
    logic    in_ready;
    logic    out_valid;
    t_count  peak_total;
    t_index  left_edge;

    int fail_count;
    int pending;
    bit calm         = 1'b0;  // no idling on either side while set
    int samples_sent = 0;
    int runs_sent    = 0;
    int spans_used   = 0;
    int stall_cycles = 0;

    window_peak_count_max_core DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_sample      (in_sample),
        .i_last        (in_last),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_peak_total  (peak_total),
        .o_left_edge   (left_edge),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    peak_window_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_sample      (in_sample),
        .i_last        (in_last),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_peak_total  (peak_total),
        .i_left_edge   (left_edge),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always #4 clk = ~clk;

    // Result side: drop ready at random unless in the calm stretch.
    always @(posedge clk) begin
        out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Watchdog: any request moving on either channel restarts the count.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no request moved for %0d cycles", stall_cycles);
            $display("window_peak_count_max_core verification failed");
            $finish;
        end
    end

    // One sample request. Idle cycles only come before valid goes up; once up,
    // valid and payload hold until the request is taken.
    task automatic push_sample(input t_sample s, input logic l);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_sample <= s;
        in_last   <= l;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        samples_sent++;
        if (l) runs_sent++;
    endtask

    // Hold the sender until every queued result has been taken. The extra edge
    // lets the checker's pending count catch up with the last request.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // window_len only changes with the block idle.
    task automatic write_span(input t_len v);
        drain();
        repeat (SETTLE) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        spans_used++;
    endtask

    function automatic t_sample pick_sample(input t_fill fill, input int pos, input t_sample base);
        case (fill)
            FILL_SMALL:   return t_sample'($urandom_range(0, 3));
            FILL_FULL:    return t_sample'($urandom());
            FILL_EXTREME: return $urandom_range(0, 1) ? '1 : '0;
            FILL_FLAT:    return base;
            default:      return pos[0] ? t_sample'(32'hFFFF_FFFF - $urandom_range(0, 2))
                                        : t_sample'($urandom_range(0, 2));
        endcase
    endfunction

    function automatic t_fill random_fill();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return FILL_SMALL;
        if (r < 70) return FILL_FULL;
        if (r < 80) return FILL_EXTREME;
        if (r < 90) return FILL_ZIGZAG;
        return FILL_FLAT;
    endfunction

    task automatic send_run(input int len, input t_fill fill);
        t_sample base;
        base = $urandom();
        for (int n = 0; n < len; n++)
            push_sample(pick_sample(fill, n, base), n == len - 1);
    endtask

    // Write one window length, then random sequences up to a sample budget.
    // Now and then the sender waits for every result before going on.
    task automatic run_phase(input t_len span, input int budget, input int max_len);
        int first;
        write_span(span);
        first = samples_sent;
        while (samples_sent - first < budget) begin
            if ($urandom_range(0, 5) == 0) drain();
            send_run($urandom_range(1, max_len), random_fill());
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, window_len still at its reset value of 3.
        // Sequences shorter than the window.
        push_sample(32'd5, 1'b1);
        push_sample(32'd0, 1'b0);
        push_sample('1, 1'b1);
        // Single peak at full scale.
        push_sample(32'd0, 1'b0);
        push_sample('1, 1'b0);
        push_sample(32'd0, 1'b1);
        // Flat top: equal neighbors are not peaks.
        push_sample('1, 1'b0);
        push_sample('1, 1'b0);
        push_sample('1, 1'b1);
        // Tie between two windows: leftmost wins.
        push_sample(32'd1, 1'b0);
        push_sample(32'd1, 1'b0);
        push_sample(32'd2, 1'b0);
        push_sample(32'd1, 1'b0);
        push_sample(32'd2, 1'b0);
        push_sample(32'd1, 1'b1);
        // Register extremes: zero saturates up to 3, all ones down to 1024.
        write_span(11'd0);
        push_sample(32'd3, 1'b0);
        push_sample(32'd9, 1'b0);
        push_sample(32'd3, 1'b1);
        write_span(11'h7FF);
        push_sample(32'd1, 1'b0);
        push_sample(32'd2, 1'b0);
        push_sample(32'd1, 1'b0);
        push_sample(32'd2, 1'b1);

        // Random phases over a spread of window lengths.
        run_phase(11'd3, 100, 14);
        run_phase(11'd4, 70, 20);
        calm = 1'b1;
        run_phase(11'd7, 90, 30);
        calm = 1'b0;
        run_phase(11'd2, 50, 12);
        run_phase(t_len'($urandom_range(8, 40)), 100, 60);

        // Widest window and an oversized write: runs shorter than the window.
        write_span(11'd1024);
        send_run($urandom_range(1, 30), random_fill());
        write_span(t_len'($urandom_range(1025, 2047)));
        send_run($urandom_range(1, 30), random_fill());

        run_phase(11'd0, 50, 15);
        run_phase(11'd3, 60, 16);

        drain();
        repeat (SETTLE + 1) @(posedge clk);

        $display("covered %0d samples in %0d sequences over %0d window_len writes,",
                 samples_sent, runs_sent, spans_used);
        $display("windows 3 to 1024 with saturation, ties, and runs shorter than the window");
        if (fail_count == 0 && pending == 0)
            $display("window_peak_count_max_core verification clean");
        else
            $display("window_peak_count_max_core verification failed");
        $finish;
    end

endmodule
